### hdl/kmbd_pkg.sv
`default_nettype none

package kmbd_pkg;

  // APB register map, one 32-bit word per register
  localparam int unsigned AddrW   = 4;
  localparam int unsigned RegIdxW = 2;

  localparam logic [RegIdxW-1:0] REG_MOUSE_EN = 2'd0;
  localparam logic [RegIdxW-1:0] REG_KBD_EN   = 2'd1;
  localparam logic [RegIdxW-1:0] REG_X_LIMIT  = 2'd2;
  localparam logic [RegIdxW-1:0] REG_Y_LIMIT  = 2'd3;

  localparam logic [9:0] X_LIMIT_RST = 10'd624;
  localparam logic [9:0] Y_LIMIT_RST = 10'd384;
  localparam logic [9:0] POS_X_RST   = 10'd320;
  localparam logic [9:0] POS_Y_RST   = 10'd200;

  // scancodes
  localparam logic [7:0] HEADER_MIN       = 8'hF8;
  localparam logic [7:0] RELEASE_BIT      = 8'h80;
  localparam logic [7:0] CAPS_CODE        = 8'd58;
  localparam logic [7:0] LEFT_SHIFT_CODE  = 8'd42;
  localparam logic [7:0] RIGHT_SHIFT_CODE = 8'd54;
  localparam logic [7:0] LEFT_SHIFT_REL   = LEFT_SHIFT_CODE | RELEASE_BIT;
  localparam logic [7:0] RIGHT_SHIFT_REL  = RIGHT_SHIFT_CODE | RELEASE_BIT;

  localparam int unsigned TableLen = 115;

  typedef enum logic [1:0] {
    TAB_PLAIN,
    TAB_CAPS,
    TAB_SHIFT
  } tab_sel_e;

  typedef struct packed {
    logic       char_valid;
    logic [6:0] ascii_char;
    logic [9:0] pointer_x;
    logic [9:0] pointer_y;
    logic [7:0] button_header;
  } res_t;

  localparam logic [7:0] TAB_PLAIN_ROM [TableLen] = '{
    8'h00,8'h1b,8'h31,8'h32,8'h33,8'h34,8'h35,8'h36,8'h37,8'h38,8'h39,8'h30,8'h2d,8'h3d,8'h08,8'h09,
    8'h71,8'h77,8'h65,8'h72,8'h74,8'h79,8'h75,8'h69,8'h6f,8'h70,8'h5b,8'h5d,8'h0d,8'h00,8'h61,8'h73,
    8'h64,8'h66,8'h67,8'h68,8'h6a,8'h6b,8'h6c,8'h3b,8'h27,8'h60,8'h00,8'h5c,8'h7a,8'h78,8'h63,8'h76,
    8'h62,8'h6e,8'h6d,8'h2c,8'h2e,8'h2f,8'h00,8'h00,8'h00,8'h20,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
    8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h2d,8'h00,8'h00,8'h00,8'h2b,8'h00,
    8'h00,8'h00,8'h00,8'h7f,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
    8'h00,8'h00,8'h00,8'h28,8'h29,8'h2f,8'h2a,8'h37,8'h38,8'h39,8'h34,8'h35,8'h36,8'h31,8'h32,8'h33,
    8'h30,8'h2e,8'h0d
  };

  localparam logic [7:0] TAB_CAPS_ROM [TableLen] = '{
    8'h00,8'h1b,8'h31,8'h32,8'h33,8'h34,8'h35,8'h36,8'h37,8'h38,8'h39,8'h30,8'h2d,8'h3d,8'h08,8'h09,
    8'h51,8'h57,8'h45,8'h52,8'h54,8'h59,8'h55,8'h49,8'h4f,8'h50,8'h5b,8'h5d,8'h0d,8'h00,8'h41,8'h53,
    8'h44,8'h46,8'h47,8'h48,8'h4a,8'h4b,8'h4c,8'h3b,8'h27,8'h60,8'h00,8'h5c,8'h5a,8'h58,8'h43,8'h56,
    8'h42,8'h4e,8'h4d,8'h2c,8'h2e,8'h2f,8'h00,8'h00,8'h00,8'h20,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
    8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h2d,8'h00,8'h00,8'h00,8'h2b,8'h00,
    8'h00,8'h00,8'h00,8'h7f,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
    8'h00,8'h00,8'h00,8'h28,8'h29,8'h2f,8'h2a,8'h37,8'h38,8'h39,8'h34,8'h35,8'h36,8'h31,8'h32,8'h33,
    8'h30,8'h2e,8'h0d
  };

  localparam logic [7:0] TAB_SHIFT_ROM [TableLen] = '{
    8'h00,8'h1b,8'h21,8'h40,8'h23,8'h24,8'h25,8'h5e,8'h26,8'h2a,8'h28,8'h29,8'h5f,8'h2b,8'h08,8'h09,
    8'h51,8'h57,8'h45,8'h52,8'h54,8'h59,8'h55,8'h49,8'h4f,8'h50,8'h7b,8'h7d,8'h0d,8'h00,8'h41,8'h53,
    8'h44,8'h46,8'h47,8'h48,8'h4a,8'h4b,8'h4c,8'h3a,8'h22,8'h7e,8'h00,8'h7c,8'h5a,8'h58,8'h43,8'h56,
    8'h42,8'h4e,8'h4d,8'h3c,8'h3e,8'h3f,8'h00,8'h00,8'h00,8'h20,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
    8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h37,8'h38,8'h00,8'h2d,8'h34,8'h00,8'h36,8'h2b,8'h00,
    8'h32,8'h00,8'h30,8'h7f,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
    8'h00,8'h00,8'h00,8'h28,8'h29,8'h2f,8'h2a,8'h37,8'h38,8'h39,8'h34,8'h35,8'h36,8'h31,8'h32,8'h33,
    8'h30,8'h2e,8'h0d
  };

  // make code to ASCII; codes past the table end give zero
  function automatic logic [6:0] key_lookup(tab_sel_e sel, logic [6:0] code);
    logic [7:0] val;
    val = 8'h00;
    if (code < 7'(TableLen)) begin
      case (sel)
        TAB_PLAIN: val = TAB_PLAIN_ROM[code];
        TAB_CAPS:  val = TAB_CAPS_ROM[code];
        TAB_SHIFT: val = TAB_SHIFT_ROM[code];
        default:   val = 8'h00;
      endcase
    end
    return val[6:0];
  endfunction

  // signed 8-bit move, clamped to 0 .. limit
  function automatic logic [9:0] move_axis(logic [9:0] pos, logic [7:0] delta,
                                           logic [9:0] limit);
    logic signed [11:0] sum;
    sum = $signed({2'b00, pos}) + $signed({{4{delta[7]}}, delta});
    if (sum < 12'sd0) begin
      return 10'd0;
    end else if (sum > $signed({2'b00, limit})) begin
      return limit;
    end else begin
      return sum[9:0];
    end
  endfunction

endpackage

`default_nettype wire

### hdl/kmbd_if.sv
`default_nettype none

interface kmbd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] scan_byte;

  modport source (output valid, output scan_byte, input ready);
  modport sink   (input valid, input scan_byte, output ready);
endinterface

interface kmbd_out_if;
  logic       valid;
  logic       ready;
  logic       char_valid;
  logic [6:0] ascii_char;
  logic [9:0] pointer_x;
  logic [9:0] pointer_y;
  logic [7:0] button_header;

  modport source (output valid, output char_valid, output ascii_char, output pointer_x,
                  output pointer_y, output button_header, input ready);
  modport sink   (input valid, input char_valid, input ascii_char, input pointer_x,
                  input pointer_y, input button_header, output ready);
endinterface

`default_nettype wire

### hdl/keyboard_mouse_byte_decoder.sv
// An accepted byte yields one registered result. Throughput: one byte per cycle
// while in_ch.ready is high; decode is a table lookup plus one clamped add.
// A two-entry output (result register plus skid register) keeps input ready high
// on a stall, so in_ch.ready only drops once both entries hold results.
// Reset (rst_ni low, asynchronous): both enables off, limits 624/384,
// position 320/200, buttons 0, no packet open, key mode normal, no result held.
`default_nettype none

module keyboard_mouse_byte_decoder (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  kmbd_in_if.sink                     in_ch,
  kmbd_out_if.source                  out_ch,
  input  logic                        psel_i,
  input  logic                        penable_i,
  input  logic                        pwrite_i,
  input  logic [kmbd_pkg::AddrW-1:0]  paddr_i,
  input  logic [31:0]                 pwdata_i,
  output logic [31:0]                 prdata_o,
  output logic                        pready_o
);
  import kmbd_pkg::*;

  // mouse packet phase: header seen -> X byte next -> Y byte next
  typedef enum logic [1:0] {
    PH_IDLE,
    PH_X,
    PH_Y
  } phase_e;

  typedef enum logic [1:0] {
    MODE_NORMAL,
    MODE_CAPS,
    MODE_LSHIFT,
    MODE_RSHIFT
  } mode_e;

  // configuration
  logic       mouse_en_q, mouse_en_d;
  logic       kbd_en_q, kbd_en_d;
  logic [9:0] x_limit_q, x_limit_d;
  logic [9:0] y_limit_q, y_limit_d;

  // decoder state
  phase_e     phase_q, phase_d;
  mode_e      mode_q, mode_d;
  logic [9:0] pos_x_q, pos_x_d;
  logic [9:0] pos_y_q, pos_y_d;
  logic [7:0] buttons_q, buttons_d;

  // output register and skid entry
  logic       out_v_q, out_v_d;
  logic       skid_v_q, skid_v_d;
  res_t       out_q, out_d;
  res_t       skid_q, skid_d;

  logic       in_fire;
  logic       out_fire;
  logic       cfg_we;
  logic [7:0] b;
  logic [6:0] ch;
  logic       mode_hit;
  mode_e      mode_new;
  tab_sel_e   tab_sel;
  res_t       res;
  logic [RegIdxW-1:0] reg_idx;

  assign b        = in_ch.scan_byte;
  assign in_ch.ready = !skid_v_q;
  assign in_fire  = in_ch.valid && !skid_v_q;
  assign out_fire = out_v_q && out_ch.ready;

  assign pready_o = 1'b1;
  assign cfg_we   = psel_i && penable_i && pwrite_i && pready_o;
  assign reg_idx  = paddr_i[AddrW-1:2];

  // register readback
  always_comb begin
    case (reg_idx)
      REG_MOUSE_EN: prdata_o = {31'd0, mouse_en_q};
      REG_KBD_EN:   prdata_o = {31'd0, kbd_en_q};
      REG_X_LIMIT:  prdata_o = {22'd0, x_limit_q};
      REG_Y_LIMIT:  prdata_o = {22'd0, y_limit_q};
      default:      prdata_o = 32'd0;
    endcase
  end

  // Key decode. Break codes never yield a character (they all sit past the
  // table end); only the release of the shift being held changes the mode.
  always_comb begin
    mode_new = mode_q;
    mode_hit = 1'b0;
    tab_sel  = TAB_PLAIN;
    case (mode_q)
      MODE_NORMAL: begin
        tab_sel = TAB_PLAIN;
        if (b == CAPS_CODE) begin
          mode_new = MODE_CAPS;
          mode_hit = 1'b1;
        end else if (b == LEFT_SHIFT_CODE) begin
          mode_new = MODE_LSHIFT;
          mode_hit = 1'b1;
        end else if (b == RIGHT_SHIFT_CODE) begin
          mode_new = MODE_RSHIFT;
          mode_hit = 1'b1;
        end
      end
      MODE_CAPS: begin
        tab_sel = TAB_CAPS;
        if (b == CAPS_CODE) begin
          mode_new = MODE_NORMAL;
          mode_hit = 1'b1;
        end
      end
      default: begin
        tab_sel = TAB_SHIFT;
        if ((mode_q == MODE_LSHIFT && b == LEFT_SHIFT_REL) ||
            (mode_q == MODE_RSHIFT && b == RIGHT_SHIFT_REL)) begin
          mode_new = MODE_NORMAL;
          mode_hit = 1'b1;
        end else if (b == CAPS_CODE) begin
          mode_new = MODE_CAPS;
          mode_hit = 1'b1;
        end
      end
    endcase
    ch = (mode_hit || b[7]) ? 7'd0 : key_lookup(tab_sel, b[6:0]);
  end

  // item and configuration update
  always_comb begin
    mouse_en_d = mouse_en_q;
    kbd_en_d   = kbd_en_q;
    x_limit_d  = x_limit_q;
    y_limit_d  = y_limit_q;
    phase_d    = phase_q;
    pos_x_d    = pos_x_q;
    pos_y_d    = pos_y_q;
    buttons_d  = buttons_q;
    res.char_valid = 1'b0;
    res.ascii_char = 7'd0;

    if (in_fire) begin
      case (phase_q)
        PH_X: begin
          if (mouse_en_q) begin
            pos_x_d = move_axis(pos_x_q, b, x_limit_q);
          end
          phase_d = PH_Y;
        end
        PH_Y: begin
          if (mouse_en_q) begin
            pos_y_d = move_axis(pos_y_q, b, y_limit_q);
          end
          phase_d = PH_IDLE;
        end
        default: begin
          // idle, and the unused phase code, both take a header or a key
          if (b >= HEADER_MIN) begin
            if (mouse_en_q) begin
              buttons_d = b;
            end
            phase_d = PH_X;
          end else if (kbd_en_q) begin
            res.ascii_char = ch;
            res.char_valid = (ch != 7'd0);
          end
        end
      endcase
    end

    if (cfg_we) begin
      case (reg_idx)
        REG_MOUSE_EN: begin
          mouse_en_d = pwdata_i[0];
          if (pwdata_i[0]) begin
            buttons_d = 8'd0;
          end
        end
        REG_KBD_EN:  kbd_en_d  = pwdata_i[0];
        REG_X_LIMIT: x_limit_d = pwdata_i[9:0];
        REG_Y_LIMIT: y_limit_d = pwdata_i[9:0];
        default: ;
      endcase
    end

    res.pointer_x     = pos_x_d;
    res.pointer_y     = pos_y_d;
    res.button_header = buttons_d;
  end

  // key mode only moves on keyboard bytes while no packet is open
  assign mode_d = (in_fire && kbd_en_q && b < HEADER_MIN &&
                   phase_q != PH_X && phase_q != PH_Y) ? mode_new : mode_q;

  // output register + skid entry
  always_comb begin
    out_v_d  = out_v_q;
    skid_v_d = skid_v_q;
    out_d    = out_q;
    skid_d   = skid_q;
    if (out_fire || !out_v_q) begin
      out_v_d  = skid_v_q || in_fire;
      out_d    = skid_v_q ? skid_q : res;
      skid_v_d = 1'b0;
    end else if (in_fire) begin
      skid_v_d = 1'b1;
      skid_d   = res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mouse_en_q <= 1'b0;
      kbd_en_q   <= 1'b0;
      x_limit_q  <= X_LIMIT_RST;
      y_limit_q  <= Y_LIMIT_RST;
      phase_q    <= PH_IDLE;
      mode_q     <= MODE_NORMAL;
      pos_x_q    <= POS_X_RST;
      pos_y_q    <= POS_Y_RST;
      buttons_q  <= 8'd0;
      out_v_q    <= 1'b0;
      skid_v_q   <= 1'b0;
    end else begin
      mouse_en_q <= mouse_en_d;
      kbd_en_q   <= kbd_en_d;
      x_limit_q  <= x_limit_d;
      y_limit_q  <= y_limit_d;
      phase_q    <= phase_d;
      mode_q     <= mode_d;
      pos_x_q    <= pos_x_d;
      pos_y_q    <= pos_y_d;
      buttons_q  <= buttons_d;
      out_v_q    <= out_v_d;
      skid_v_q   <= skid_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign out_ch.valid         = out_v_q;
  assign out_ch.char_valid    = out_q.char_valid;
  assign out_ch.ascii_char    = out_q.ascii_char;
  assign out_ch.pointer_x     = out_q.pointer_x;
  assign out_ch.pointer_y     = out_q.pointer_y;
  assign out_ch.button_header = out_q.button_header;

`ifndef NO_ASSERTIONS
  // skid entry only fills behind a held result
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |-> out_v_q)
    else $error("skid entry valid with empty output register");

  // an X move with the mouse on never leaves the position past the limit
  a_x_clamped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && phase_q == PH_X && mouse_en_q && !cfg_we) |=>
      (pos_x_q <= $past(x_limit_q)))
    else $error("pointer X above limit after move");

  // bytes inside a mouse packet never produce a character
  a_no_char_in_packet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && (phase_q == PH_X || phase_q == PH_Y)) |-> !res.char_valid)
    else $error("character produced from a mouse packet byte");

  // flag and character agree in every delivered result
  a_char_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q |-> (out_q.char_valid == (out_q.ascii_char != 7'd0)))
    else $error("char_valid disagrees with ascii_char");
`endif

endmodule

`default_nettype wire

### bench/kmbd_decode_checker.sv
module kmbd_decode_checker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  kmbd_in_if                          in_ch,
  kmbd_out_if                         out_ch,
  input  logic                        psel_i,
  input  logic                        penable_i,
  input  logic                        pwrite_i,
  input  logic [kmbd_pkg::AddrW-1:0]  paddr_i,
  input  logic [31:0]                 pwdata_i,
  input  logic                        pready_i,
  output int                          pending_o,
  output int                          fail_count_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic [1:0] {PKT_IDLE, PKT_X_NEXT, PKT_Y_NEXT} pkt_phase_e;
  typedef enum logic [1:0] {MODE_NORMAL, MODE_CAPS, MODE_LSHIFT, MODE_RSHIFT} key_mode_e;

  localparam logic [7:0] KEY_CAPS      = 8'd58;
  localparam logic [7:0] KEY_LSHIFT    = 8'd42;
  localparam logic [7:0] KEY_RSHIFT    = 8'd54;
  localparam logic [7:0] BREAK_FLAG    = 8'h80;
  localparam logic [7:0] KEY_LSHIFT_UP = KEY_LSHIFT | BREAK_FLAG;
  localparam logic [7:0] KEY_RSHIFT_UP = KEY_RSHIFT | BREAK_FLAG;
  localparam logic [7:0] MOUSE_HEADER  = 8'hF8;
  localparam int unsigned ROM_DEPTH    = 115;

  localparam logic [9:0] HOME_X  = 10'd320;
  localparam logic [9:0] HOME_Y  = 10'd200;
  localparam logic [9:0] X_MAX_0 = 10'd624;
  localparam logic [9:0] Y_MAX_0 = 10'd384;

  localparam logic [7:0] PLAIN_KEYS [ROM_DEPTH] = '{
    8'h00, 8'h1b, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36,
    8'h37, 8'h38, 8'h39, 8'h30, 8'h2d, 8'h3d, 8'h08, 8'h09,
    8'h71, 8'h77, 8'h65, 8'h72, 8'h74, 8'h79, 8'h75, 8'h69,
    8'h6f, 8'h70, 8'h5b, 8'h5d, 8'h0d, 8'h00, 8'h61, 8'h73,
    8'h64, 8'h66, 8'h67, 8'h68, 8'h6a, 8'h6b, 8'h6c, 8'h3b,
    8'h27, 8'h60, 8'h00, 8'h5c, 8'h7a, 8'h78, 8'h63, 8'h76,
    8'h62, 8'h6e, 8'h6d, 8'h2c, 8'h2e, 8'h2f, 8'h00, 8'h00,
    8'h00, 8'h20, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h2d, 8'h00, 8'h00, 8'h00, 8'h2b, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h7f, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h28, 8'h29, 8'h2f, 8'h2a, 8'h37,
    8'h38, 8'h39, 8'h34, 8'h35, 8'h36, 8'h31, 8'h32, 8'h33,
    8'h30, 8'h2e, 8'h0d
  };

  localparam logic [7:0] SHIFT_KEYS [ROM_DEPTH] = '{
    8'h00, 8'h1b, 8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5e,
    8'h26, 8'h2a, 8'h28, 8'h29, 8'h5f, 8'h2b, 8'h08, 8'h09,
    8'h51, 8'h57, 8'h45, 8'h52, 8'h54, 8'h59, 8'h55, 8'h49,
    8'h4f, 8'h50, 8'h7b, 8'h7d, 8'h0d, 8'h00, 8'h41, 8'h53,
    8'h44, 8'h46, 8'h47, 8'h48, 8'h4a, 8'h4b, 8'h4c, 8'h3a,
    8'h22, 8'h7e, 8'h00, 8'h7c, 8'h5a, 8'h58, 8'h43, 8'h56,
    8'h42, 8'h4e, 8'h4d, 8'h3c, 8'h3e, 8'h3f, 8'h00, 8'h00,
    8'h00, 8'h20, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h37,
    8'h38, 8'h00, 8'h2d, 8'h34, 8'h00, 8'h36, 8'h2b, 8'h00,
    8'h32, 8'h00, 8'h30, 8'h7f, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h28, 8'h29, 8'h2f, 8'h2a, 8'h37,
    8'h38, 8'h39, 8'h34, 8'h35, 8'h36, 8'h31, 8'h32, 8'h33,
    8'h30, 8'h2e, 8'h0d
  };

  logic       mouse_on, keys_on;
  logic [9:0] x_max, y_max;
  pkt_phase_e pkt_phase;
  key_mode_e  key_mode;
  logic [9:0] cur_x, cur_y;
  logic [7:0] buttons;

  kmbd_pkg::res_t predicted_results [$];

  // caps table is the plain one with letters raised
  function automatic logic [6:0] key_char(key_mode_e mode, logic [7:0] code);
    logic [7:0] c;
    if (code >= ROM_DEPTH) return 7'd0;
    case (mode)
      MODE_NORMAL: c = PLAIN_KEYS[code];
      MODE_CAPS: begin
        c = PLAIN_KEYS[code];
        if (c >= "a" && c <= "z") c = c - 8'h20;
      end
      default: c = SHIFT_KEYS[code];
    endcase
    return c[6:0];
  endfunction

  function automatic logic [9:0] clamp_move(logic [9:0] pos, logic [7:0] step,
                                            logic [9:0] lim);
    int sum;
    sum = int'(pos) + int'($signed(step));
    if (sum > int'(lim)) sum = int'(lim);
    if (sum < 0) sum = 0;
    return sum[9:0];
  endfunction

  function automatic int field_miss(string name, int unsigned want, int unsigned got);
    if (want == got) return 0;
    $error("%s: expected %0d, got %0d", name, want, got);
    return 1;
  endfunction

  task automatic translate_key(input logic [7:0] code, output logic [6:0] ch);
    ch = 7'd0;
    // break codes other than the shift releases are dropped
    if (code[7] && code != KEY_LSHIFT_UP && code != KEY_RSHIFT_UP) return;
    case (key_mode)
      MODE_NORMAL: begin
        if (code == KEY_CAPS) key_mode = MODE_CAPS;
        else if (code == KEY_LSHIFT) key_mode = MODE_LSHIFT;
        else if (code == KEY_RSHIFT) key_mode = MODE_RSHIFT;
        else ch = key_char(key_mode, code);
      end
      MODE_CAPS: begin
        if (code == KEY_CAPS) key_mode = MODE_NORMAL;
        else ch = key_char(key_mode, code);
      end
      default: begin
        if ((key_mode == MODE_LSHIFT && code == KEY_LSHIFT_UP) ||
            (key_mode == MODE_RSHIFT && code == KEY_RSHIFT_UP)) key_mode = MODE_NORMAL;
        else if (code == KEY_CAPS) key_mode = MODE_CAPS;
        else ch = key_char(key_mode, code);
      end
    endcase
  endtask

  task automatic decode_byte(input logic [7:0] b, output kmbd_pkg::res_t res);
    logic [6:0] ch;
    ch = 7'd0;
    case (pkt_phase)
      PKT_X_NEXT: begin
        if (mouse_on) cur_x = clamp_move(cur_x, b, x_max);
        pkt_phase = PKT_Y_NEXT;
      end
      PKT_Y_NEXT: begin
        if (mouse_on) cur_y = clamp_move(cur_y, b, y_max);
        pkt_phase = PKT_IDLE;
      end
      default: begin
        if (b >= MOUSE_HEADER) begin
          if (mouse_on) buttons = b;
          pkt_phase = PKT_X_NEXT;
        end else if (keys_on) begin
          translate_key(b, ch);
        end
      end
    endcase
    res.char_valid    = (ch != 7'd0);
    res.ascii_char    = ch;
    res.pointer_x     = cur_x;
    res.pointer_y     = cur_y;
    res.button_header = buttons;
  endtask

  task automatic write_register(input logic [kmbd_pkg::RegIdxW-1:0] idx,
                                input logic [31:0] data);
    case (idx)
      kmbd_pkg::REG_MOUSE_EN: begin
        mouse_on = data[0];
        if (data[0]) buttons = 8'd0;
      end
      kmbd_pkg::REG_KBD_EN:  keys_on = data[0];
      kmbd_pkg::REG_X_LIMIT: x_max = data[9:0];
      kmbd_pkg::REG_Y_LIMIT: y_max = data[9:0];
      default: ;
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    kmbd_pkg::res_t got, want;
    int misses;
    if (!rst_ni) begin
      mouse_on     = 1'b0;
      keys_on      = 1'b0;
      x_max        = X_MAX_0;
      y_max        = Y_MAX_0;
      pkt_phase    = PKT_IDLE;
      key_mode     = MODE_NORMAL;
      cur_x        = HOME_X;
      cur_y        = HOME_Y;
      buttons      = 8'd0;
      predicted_results.delete();
      pending_o    = 0;
      fail_count_o = 0;
    end else begin
      if (psel_i && penable_i && pwrite_i && pready_i)
        write_register(paddr_i[kmbd_pkg::AddrW-1:2], pwdata_i);
      // retire before predicting: a byte taken this edge cannot have its result out yet
      if (out_ch.valid && out_ch.ready) begin
        got = {out_ch.char_valid, out_ch.ascii_char, out_ch.pointer_x, out_ch.pointer_y,
               out_ch.button_header};
        if (predicted_results.size() == 0) begin
          $error("result item with no byte outstanding");
          fail_count_o++;
        end else begin
          want   = predicted_results.pop_front();
          misses = field_miss("char_valid", want.char_valid, got.char_valid)
                 + field_miss("ascii_char", want.ascii_char, got.ascii_char)
                 + field_miss("pointer_x", want.pointer_x, got.pointer_x)
                 + field_miss("pointer_y", want.pointer_y, got.pointer_y)
                 + field_miss("button_header", want.button_header, got.button_header);
          fail_count_o += misses;
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        decode_byte(in_ch.scan_byte, want);
        predicted_results.push_back(want);
      end
      pending_o = predicted_results.size();
    end
  end

endmodule

### bench/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import kmbd_pkg::*;

  // run shape: a directed opening, then random phases with fresh register settings
  localparam int RANDOM_PHASES   = 8;
  localparam int ITEMS_PER_PHASE = 250;
  localparam int HOLD_PHASE      = 2;    // phase in which the receiver backs off for long
  localparam int LONG_HOLD       = 100;  // cycles of that back-off
  localparam int DRAIN_CYCLES    = 20;   // quiet time after the last phase, before the verdict
  localparam int CYCLE_LIMIT     = 200_000;

  // bytes fed with both enables off (keys and a mouse packet): nothing may change
  localparam logic [7:0] OFF_BYTES [5] = '{8'h1E, 8'hF9, 8'h7F, 8'h80, 8'h3A};

  // bytes fed with both enables on, x limit at top and y limit at zero
  localparam logic [7:0] ON_BYTES [22] = '{
    8'h1E,         // plain letter
    8'h00,         // lowest code, table gives nothing
    8'h72, 8'h73,  // last table entry, then first code past the end
    8'h9E,         // ordinary break code, dropped
    8'h3A, 8'h10,  // caps lock on, upper-case letter
    8'h3A,         // caps lock off
    8'h2A, 8'h02,  // left shift held, shifted digit
    8'hB6,         // release of the shift that is not held: dropped
    8'hAA,         // left shift released
    8'h36, 8'h3A,  // right shift held, caps from shift mode
    8'h36, 8'hB6,  // shift press and release while in caps: no mode change
    8'hFF, 8'h7F, 8'h80,  // packet: x up by the most, y down by the most
    8'hF8, 8'h80, 8'h7F   // packet: x down by the most, y clamps at its zero limit
  };

  logic        clk_i;
  logic        rst_ni;
  logic        psel_i, penable_i, pwrite_i;
  logic [AddrW-1:0] paddr_i;
  logic [31:0] pwdata_i;
  logic [31:0] prdata_o;
  logic        pready_o;

  int fail_count;
  int pending;
  int bytes_sent;
  int cycle_count = 0;
  bit sender_idles;
  bit receiver_stalls;
  bit hold_request;

  kmbd_in_if  in_ch ();
  kmbd_out_if out_ch ();

  keyboard_mouse_byte_decoder DUT (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .psel_i    (psel_i),
    .penable_i (penable_i),
    .pwrite_i  (pwrite_i),
    .paddr_i   (paddr_i),
    .pwdata_i  (pwdata_i),
    .prdata_o  (prdata_o),
    .pready_o  (pready_o)
  );

  // watches both channels and the register port, predicts and compares
  kmbd_decode_checker CHECK (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_ch        (in_ch),
    .out_ch       (out_ch),
    .psel_i       (psel_i),
    .penable_i    (penable_i),
    .pwrite_i     (pwrite_i),
    .paddr_i      (paddr_i),
    .pwdata_i     (pwdata_i),
    .pready_i     (pready_o),
    .pending_o    (pending),
    .fail_count_o (fail_count)
  );

  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // hard stop in case a handshake hangs
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // one item on the input channel; may idle for a burst first.
  // valid stays high from one item to the next when there is no gap.
  task automatic send_byte(input logic [7:0] b);
    if (sender_idles && $urandom_range(0, 4) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
    end
    in_ch.valid     <= 1'b1;
    in_ch.scan_byte <= b;
    do @(posedge clk_i); while (!in_ch.ready);
    @(negedge clk_i);
    bytes_sent++;
  endtask

  // drop valid and wait until every predicted result has come out
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  // APB write: setup cycle, access cycle; psel is released by the caller so that
  // back-to-back writes keep it high
  task automatic cfg_write(input logic [RegIdxW-1:0] idx, input logic [31:0] value);
    psel_i    <= 1'b1;
    penable_i <= 1'b0;
    pwrite_i  <= 1'b1;
    paddr_i   <= {idx, 2'b00};
    pwdata_i  <= value;
    @(negedge clk_i);
    penable_i <= 1'b1;
    do @(posedge clk_i); while (!pready_o);
    @(negedge clk_i);
  endtask

  task automatic apply_config(input bit mouse_en, input bit keys_en,
                              input logic [9:0] x_max, input logic [9:0] y_max);
    cfg_write(REG_MOUSE_EN, 32'(mouse_en));
    cfg_write(REG_KBD_EN, 32'(keys_en));
    cfg_write(REG_X_LIMIT, 32'(x_max));
    cfg_write(REG_Y_LIMIT, 32'(y_max));
    psel_i    <= 1'b0;
    penable_i <= 1'b0;
  endtask

  // limits: extremes now and then, otherwise anywhere in range
  function automatic logic [9:0] pick_limit();
    case ($urandom_range(0, 4))
      0:       return 10'd0;
      1:       return 10'd1023;
      default: return 10'($urandom_range(0, 1023));
    endcase
  endfunction

  // signed mouse step, full swing in either direction often
  function automatic logic [7:0] pick_step();
    case ($urandom_range(0, 5))
      0:       return 8'h7F;
      1:       return 8'h80;
      default: return 8'($urandom);
    endcase
  endfunction

  // one random event: mostly whole mouse packets and key strokes with random
  // content, some mode keys, the rest raw bytes of any value
  task automatic send_event();
    int unsigned pick;
    logic [7:0] code;
    pick = $urandom_range(0, 19);
    if (pick < 7) begin
      send_byte(8'($urandom_range(int'(HEADER_MIN), 255)));
      send_byte(pick_step());
      send_byte(pick_step());
    end else if (pick < 14) begin
      if ($urandom_range(0, 4) == 0) code = 8'($urandom_range(0, 127));
      else code = 8'($urandom_range(0, TableLen - 1));
      send_byte(code);
      if ($urandom_range(0, 1) == 1) send_byte(code | RELEASE_BIT);
    end else if (pick < 17) begin
      case ($urandom_range(0, 4))
        0:       send_byte(CAPS_CODE);
        1:       send_byte(LEFT_SHIFT_CODE);
        2:       send_byte(RIGHT_SHIFT_CODE);
        3:       send_byte(LEFT_SHIFT_REL);
        default: send_byte(RIGHT_SHIFT_REL);
      endcase
    end else begin
      send_byte(8'($urandom));
    end
  endtask

  // receiver: ready and stalled in random stretches, one long
  // back-off on request while the sender keeps offering
  initial begin : result_sink
    bit level;
    bit held;
    int unsigned span;
    held = 1'b0;
    out_ch.ready = 1'b0;
    @(negedge clk_i);
    forever begin
      if (hold_request && !held) begin
        held  = 1'b1;
        level = 1'b0;
        span  = LONG_HOLD;
      end else if (receiver_stalls && $urandom_range(0, 3) == 0) begin
        level = 1'b0;
        span  = $urandom_range(1, 6);
      end else begin
        level = 1'b1;
        span  = $urandom_range(1, 8);
      end
      out_ch.ready <= level;
      repeat (span) @(negedge clk_i);
    end
  end

  initial begin : stimulus
    bit mouse_en, keys_en;
    rst_ni          = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.scan_byte = 8'd0;
    psel_i          = 1'b0;
    penable_i       = 1'b0;
    pwrite_i        = 1'b0;
    paddr_i         = '0;
    pwdata_i        = 32'd0;
    sender_idles    = 1'b1;
    receiver_stalls = 1'b1;
    hold_request    = 1'b0;
    bytes_sent      = 0;

    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset settings: both enables off, so keys and packets change nothing
    foreach (OFF_BYTES[i]) send_byte(OFF_BYTES[i]);
    settle();

    apply_config(1'b1, 1'b1, 10'd1023, 10'd0);
    foreach (ON_BYTES[i]) send_byte(ON_BYTES[i]);
    settle();

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      mouse_en = ($urandom_range(0, 4) != 0);
      keys_en  = ($urandom_range(0, 4) != 0);
      // make sure each enable spends a phase off, and the limits hit both ends
      if (ph == 1) mouse_en = 1'b0;
      if (ph == 3) keys_en = 1'b0;
      if (ph == 0) apply_config(1'b1, 1'b1, 10'd0, 10'd1023);
      else apply_config(mouse_en, keys_en, pick_limit(), pick_limit());

      // last phase runs flat out on both sides
      if (ph == RANDOM_PHASES - 1) begin
        sender_idles    = 1'b0;
        receiver_stalls = 1'b0;
      end
      if (ph == HOLD_PHASE) hold_request = 1'b1;

      bytes_sent = 0;
      while (bytes_sent < ITEMS_PER_PHASE) send_event();
      settle();
    end

    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

### keyboard_mouse_byte_decoder.f
hdl/kmbd_pkg.sv
hdl/kmbd_if.sv
hdl/keyboard_mouse_byte_decoder.sv
bench/kmbd_decode_checker.sv
bench/testbench.sv
